>>> rtl/byte_masked_write_cache_assert.svh
// Assertion macros shared by the cache RTL.
// Depends on nothing; files that assert include this header.
`ifndef BYTE_MASKED_WRITE_CACHE_ASSERT_SVH
`define BYTE_MASKED_WRITE_CACHE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BMWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BMWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bmwc_pkg.sv
// Types and constants of the byte-masked write cache.
// No dependencies; used by every other RTL file but the assertion header.
`default_nettype none
package bmwc_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int NUM_ENTRIES = 16;
  localparam int ADDR_BITS   = 48;
  localparam int SIZE_BITS   = ADDR_BITS + 1;
  localparam int OFF_BITS    = $clog2(BLOCK_BYTES);
  localparam int ENTRY_BITS  = $clog2(NUM_ENTRIES);
  localparam int BLOCK_BITS  = ADDR_BITS - OFF_BITS;
  localparam int MEM_DEPTH   = NUM_ENTRIES * BLOCK_BYTES;
  localparam int MEM_BITS    = ENTRY_BITS + OFF_BITS;
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 64;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_TRIM  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDOUT,
    S_FLSCAN,
    S_FLOUT
  } state_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           write_data;
    logic [7:0]           backing_data;
    logic [3:0]           entry_index;
    logic                 end_of_burst;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [ADDR_BITS-1:0] byte_address;
    logic                 hit;
    logic [1:0]           status;
    logic                 last;
  } out_item_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    action_t              action;
    logic                 beyond;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           write_data;
    logic [7:0]           backing_data;
    logic [ENTRY_BITS-1:0] entry_index;
    logic                 end_of_burst;
  } work_item_t;

  // Queue handshake driven by the back end.
  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

endpackage
`default_nettype wire

>>> rtl/bmwc_ifs.sv
// Valid/ready channel interfaces for cache items and results.
// Depends on bmwc_pkg.
`default_nettype none
interface bmwc_in_if;
  logic               valid;
  logic               ready;
  bmwc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmwc_out_if;
  logic                valid;
  logic                ready;
  bmwc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bmwc_front.sv
// Front end: decode the action and check the address against device size.
// Depends on bmwc_pkg.
`default_nettype none
module bmwc_front (
  input  wire bmwc_pkg::in_item_t              item,
  input  wire logic [bmwc_pkg::SIZE_BITS-1:0]  device_size,
  output bmwc_pkg::work_item_t                 work
);
  import bmwc_pkg::*;

  always_comb begin
    work.action       = action_t'(item.action);
    work.beyond       = {1'b0, item.address} >= device_size;
    work.address      = item.address;
    work.write_data   = item.write_data;
    work.backing_data = item.backing_data;
    work.entry_index  = item.entry_index[ENTRY_BITS-1:0];
    work.end_of_burst = item.end_of_burst;
  end
endmodule
`default_nettype wire

>>> rtl/bmwc_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on bmwc_pkg.
`default_nettype none
module bmwc_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire bmwc_pkg::work_item_t   push_item,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        valid,
  output bmwc_pkg::work_item_t        head
);
  import bmwc_pkg::*;

  work_item_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/bmwc_back.sv
// Back end: tag table, byte memory, flush walk and the result register.
// Depends on bmwc_pkg and the assertion header.
`default_nettype none
`include "byte_masked_write_cache_assert.svh"
module bmwc_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [bmwc_pkg::SIZE_BITS-1:0]  device_size,
  input  wire bmwc_pkg::work_item_t            head,
  input  wire logic                            head_valid,
  output bmwc_pkg::queue_ctl_t                 qctl,
  output logic                                 out_valid,
  output bmwc_pkg::out_item_t                  out_item,
  input  wire logic                            out_ready
);
  import bmwc_pkg::*;

  state_t state, state_next;
  work_item_t cur;

  logic                  used  [NUM_ENTRIES];
  logic [BLOCK_BITS-1:0] blk   [NUM_ENTRIES];
  logic [BLOCK_BYTES-1:0] mask [NUM_ENTRIES];
  logic [7:0]            mem   [MEM_DEPTH];
  logic [7:0]            mem_q;

  logic [BLOCK_BYTES-1:0] work_mask;
  logic [OFF_BITS-1:0]    bitp;

  logic [OFF_BITS-1:0]   off;
  logic [BLOCK_BITS-1:0] cur_block;
  logic                  hit_any, full;
  logic [ENTRY_BITS-1:0] hit_idx, free_idx, sel;
  logic                  is_rw, byte_valid, ent_used;
  logic [BLOCK_BYTES-1:0] ent_mask;
  logic [ADDR_BITS-1:0]  ent_base;
  logic [SIZE_BITS-1:0]  diff;
  logic                  out_free, flush_last;
  logic [MEM_BITS-1:0]   raddr;

  logic      emit, do_write, do_free, do_trim, load_work, flush_step, scan_step;
  out_item_t emit_item;

  assign off       = cur.address[OFF_BITS-1:0];
  assign cur_block = cur.address[ADDR_BITS-1:OFF_BITS];
  assign is_rw     = cur.action == ACT_WRITE || cur.action == ACT_READ;
  assign out_free  = !out_valid || out_ready;
  assign ent_used  = used[cur.entry_index];
  assign ent_mask  = mask[cur.entry_index];
  assign ent_base  = {blk[cur.entry_index], {OFF_BITS{1'b0}}};
  assign diff      = device_size - {1'b0, ent_base};
  assign flush_last = (work_mask & ~(BLOCK_BYTES'(1) << bitp)) == '0;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    full     = 1'b1;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (used[e] && blk[e] == cur_block) begin
        hit_any = 1'b1;
        hit_idx = ENTRY_BITS'(e);
      end
      if (!used[e]) begin
        full     = 1'b0;
        free_idx = ENTRY_BITS'(e);
      end
    end
    sel = hit_any ? hit_idx : free_idx;
  end

  assign byte_valid = hit_any && mask[hit_idx][off];
  // Keep the flush address while a flushed byte waits for the result register.
  assign raddr = (state == S_FLSCAN || state == S_FLOUT) ? {cur.entry_index, bitp}
                                                         : {hit_idx, off};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (is_rw && !cur.beyond && cur.action == ACT_READ && byte_valid) begin
          state_next = S_RDOUT;
        end else if (cur.action == ACT_FLUSH && ent_used && ent_mask != '0) begin
          state_next = S_FLSCAN;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_RDOUT: begin
        if (out_free) state_next = S_IDLE;
      end
      S_FLSCAN: begin
        if (work_mask[bitp]) state_next = S_FLOUT;
      end
      S_FLOUT: begin
        if (out_free) state_next = flush_last ? S_IDLE : S_FLSCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Actions and result payload.
  always_comb begin
    emit       = 1'b0;
    do_write   = 1'b0;
    do_free    = 1'b0;
    do_trim    = 1'b0;
    load_work  = 1'b0;
    flush_step = 1'b0;
    scan_step  = 1'b0;
    emit_item  = '0;
    qctl.valid = head_valid;
    qctl.pop   = 1'b0;
    unique case (state)
      S_IDLE: qctl.pop = head_valid;
      S_EXEC: begin
        if (is_rw) begin
          emit_item.byte_address = cur.address;
          emit_item.last         = cur.end_of_burst;
          if (cur.beyond) begin
            emit = out_free;
            emit_item.status = ST_BEYOND;
          end else if (cur.action == ACT_WRITE) begin
            emit = out_free;
            if (!hit_any && full) begin
              emit_item.status = ST_FULL;
            end else begin
              emit_item.status = ST_OK;
              do_write = out_free;
            end
          end else if (!byte_valid) begin
            emit = out_free;
            emit_item.data_byte = cur.backing_data;
          end
        end else begin
          emit_item.last = 1'b1;
          if (!ent_used) begin
            emit = out_free;
            emit_item.status = ST_EMPTY;
          end else if (cur.action == ACT_TRIM) begin
            emit = out_free;
            do_trim = out_free;
            emit_item.byte_address = ent_base;
          end else if (ent_mask == '0) begin
            emit = out_free;
            do_free = out_free;
            emit_item.status = ST_EMPTY;
            emit_item.byte_address = ent_base;
          end else begin
            do_free   = 1'b1;
            load_work = 1'b1;
          end
        end
      end
      S_RDOUT: begin
        emit = out_free;
        emit_item.data_byte    = mem_q;
        emit_item.byte_address = cur.address;
        emit_item.hit          = 1'b1;
        emit_item.last         = cur.end_of_burst;
      end
      S_FLSCAN: scan_step = !work_mask[bitp];
      S_FLOUT: begin
        emit = out_free;
        flush_step = out_free;
        emit_item.data_byte    = mem_q;
        emit_item.byte_address = {ent_base[ADDR_BITS-1:OFF_BITS], bitp};
        emit_item.last         = flush_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (qctl.pop) cur <= head;
    mem_q <= mem[raddr];
    if (do_write) mem[{sel, off}] <= cur.write_data;
    if (load_work) begin
      work_mask <= ent_mask;
      bitp      <= '0;
    end else if (scan_step) begin
      bitp <= bitp + 1'b1;
    end else if (flush_step) begin
      work_mask[bitp] <= 1'b0;
      bitp <= bitp + 1'b1;
    end
    if (do_write && !hit_any) blk[sel] <= cur_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        used[e] <= 1'b0;
        mask[e] <= '0;
      end
    end else begin
      if (do_write) begin
        used[sel] <= 1'b1;
        mask[sel] <= (hit_any ? mask[sel] : '0) | (BLOCK_BYTES'(1) << off);
      end
      if (do_free) begin
        used[cur.entry_index] <= 1'b0;
        mask[cur.entry_index] <= '0;
      end
      if (do_trim) begin
        if (device_size <= {1'b0, ent_base}) begin
          used[cur.entry_index] <= 1'b0;
          mask[cur.entry_index] <= '0;
        end else if (diff < SIZE_BITS'(BLOCK_BYTES)) begin
          mask[cur.entry_index] <=
            ent_mask & ((BLOCK_BYTES'(1) << diff[OFF_BITS-1:0]) - BLOCK_BYTES'(1));
        end
      end
    end
  end

  // Result register: load a new result once the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_item <= emit_item;
  end

  `BMWC_ASSERT(a_flout_has_work, (state == S_FLOUT) |-> (work_mask != '0), "flush walk with empty mask")
  `BMWC_ASSERT(a_write_in_exec, do_write |-> (state == S_EXEC && out_free), "byte written outside exec")
  `BMWC_ASSERT(a_flush_ends_idle, (state == S_FLOUT && emit && flush_last) |=> (state == S_IDLE), "flush did not end")
  `BMWC_ASSERT_ALWAYS(a_pop_only_idle, qctl.pop |-> (state == S_IDLE && head_valid), "pop outside idle")
endmodule
`default_nettype wire

>>> rtl/byte_masked_write_cache.sv
// Top level of the byte-masked write cache: APB register, front, queue, back.
// Depends on bmwc_pkg, bmwc_ifs and the three submodules.
//
//   channel  dir   handshake            payload
//   req      in    valid/ready          in_item_t
//   rsp      out   valid/ready          out_item_t
//   apb      in    psel/penable/pready  device_size at 0x0
//
// Write, read-miss and error items go from the queue head via IDLE and EXEC
// to the result register; a read hit also passes RDOUT. A flush scans the
// mask in FLSCAN, emits set bytes in FLOUT, over the single memory read port.
// Reset clears the used bits and masks at once; no clearing pass.
// A full result register stalls the back end; the front stalls when the
// two-entry queue is full.
`default_nettype none
module byte_masked_write_cache (
  input  wire logic                               clk,
  input  wire logic                               rst,
  bmwc_in_if.sink                                 req,
  bmwc_out_if.source                              rsp,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bmwc_pkg::PADDR_BITS-1:0]    paddr,
  input  wire logic [bmwc_pkg::PDATA_BITS-1:0]    pwdata,
  output logic      [bmwc_pkg::PDATA_BITS-1:0]    prdata,
  output logic                                    pready
);
  import bmwc_pkg::*;

  logic [SIZE_BITS-1:0] device_size;
  work_item_t           push_item, head;
  logic                 q_full;
  logic                 q_valid;
  queue_ctl_t           qctl;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? '0 : PDATA_BITS'(device_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_size <= '0;
    end else if (psel && penable && pwrite && !paddr[3]) begin
      device_size <= pwdata[SIZE_BITS-1:0];
    end
  end

  assign req.ready = !q_full;

  bmwc_front u_front (
    .item        (req.data),
    .device_size (device_size),
    .work        (push_item)
  );

  bmwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req.valid && !q_full),
    .push_item (push_item),
    .full      (q_full),
    .pop       (qctl.pop),
    .valid     (q_valid),
    .head      (head)
  );

  bmwc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .device_size (device_size),
    .head        (head),
    .head_valid  (q_valid),
    .qctl        (qctl),
    .out_valid   (rsp.valid),
    .out_item    (rsp.data),
    .out_ready   (rsp.ready)
  );
endmodule
`default_nettype wire

>>> verif/byte_masked_write_cache_tb.sv
// Self-checking testbench for byte_masked_write_cache: random and directed
// byte writes, reads, flushes and trims against a behavioral cache predictor.
// Depends on bmwc_pkg, bmwc_ifs and the cache RTL.
`timescale 1ns / 100ps
`default_nettype none
module byte_masked_write_cache_tb;
  import bmwc_pkg::*;

  localparam int WDOG_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;

  bmwc_in_if  req_if ();
  bmwc_out_if rsp_if ();

  byte_masked_write_cache DUT (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the cache
  logic [SIZE_BITS-1:0]  dev_size;
  logic                  ent_used [NUM_ENTRIES];
  logic [BLOCK_BITS-1:0] ent_blk [NUM_ENTRIES];
  logic [63:0]           ent_mask [NUM_ENTRIES];
  logic [7:0]            ent_bytes [NUM_ENTRIES][BLOCK_BYTES];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors = 0;
  bit        idle_on = 1'b1;
  bit        want_long_hold = 1'b0;
  logic [63:0] hot_blk [20];

  function automatic out_item_t mk(logic [7:0] d, logic [ADDR_BITS-1:0] a,
                                   logic h, status_t s, logic l);
    out_item_t r;
    r.data_byte = d; r.byte_address = a; r.hit = h; r.status = s; r.last = l;
    return r;
  endfunction

  task automatic cache_apply(in_item_t it);
    logic [ADDR_BITS-1:0]  a;
    logic [BLOCK_BITS-1:0] blk;
    logic [OFF_BITS-1:0]   off;
    logic [ADDR_BITS-1:0]  base;
    logic [SIZE_BITS-1:0]  diff;
    logic [63:0]           m;
    action_t act;
    int e;
    a = it.address; blk = a[ADDR_BITS-1:OFF_BITS]; off = a[OFF_BITS-1:0];
    act = action_t'(it.action);
    e = -1;
    if (act == ACT_WRITE || act == ACT_READ) begin
      if ({1'b0, a} >= dev_size) begin
        expected_results.push_back(mk(8'd0, a, 1'b0, ST_BEYOND, it.end_of_burst));
        return;
      end
      for (int k = NUM_ENTRIES - 1; k >= 0; k--)
        if (ent_used[k] && ent_blk[k] == blk) e = k;
      if (act == ACT_WRITE) begin
        if (e < 0) begin
          for (int k = NUM_ENTRIES - 1; k >= 0; k--)
            if (!ent_used[k]) e = k;
          if (e < 0) begin
            expected_results.push_back(mk(8'd0, a, 1'b0, ST_FULL, it.end_of_burst));
            return;
          end
          ent_used[e] = 1'b1; ent_blk[e] = blk; ent_mask[e] = '0;
        end
        ent_bytes[e][off] = it.write_data;
        ent_mask[e][off] = 1'b1;
        expected_results.push_back(mk(8'd0, a, 1'b0, ST_OK, it.end_of_burst));
      end else if (e >= 0 && ent_mask[e][off]) begin
        expected_results.push_back(mk(ent_bytes[e][off], a, 1'b1, ST_OK, it.end_of_burst));
      end else begin
        expected_results.push_back(mk(it.backing_data, a, 1'b0, ST_OK, it.end_of_burst));
      end
      return;
    end
    e = it.entry_index;
    if (!ent_used[e]) begin
      expected_results.push_back(mk(8'd0, '0, 1'b0, ST_EMPTY, 1'b1));
      return;
    end
    base = {ent_blk[e], {OFF_BITS{1'b0}}};
    if (act == ACT_FLUSH) begin
      m = ent_mask[e];
      ent_used[e] = 1'b0; ent_mask[e] = '0;
      if (m == '0) begin
        expected_results.push_back(mk(8'd0, base, 1'b0, ST_EMPTY, 1'b1));
        return;
      end
      for (int b = 0; b < BLOCK_BYTES; b++)
        if (m[b])
          expected_results.push_back(mk(ent_bytes[e][b], base + b, 1'b0, ST_OK,
                                        (m >> b) == 64'd1));
      return;
    end
    if (dev_size <= {1'b0, base}) begin
      ent_used[e] = 1'b0; ent_mask[e] = '0;
    end else begin
      diff = dev_size - {1'b0, base};
      if (diff < BLOCK_BYTES) ent_mask[e] &= (64'd1 << diff[5:0]) - 64'd1;
    end
    expected_results.push_back(mk(8'd0, base, 1'b0, ST_OK, 1'b1));
  endtask

  // driver
  int tx_wait = 0;
  logic nxt_valid;
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      nxt_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        cache_apply(req_if.data);
        nxt_valid = 1'b0;
        tx_wait = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (!nxt_valid) begin
        if (tx_wait > 0) tx_wait--;
        else if (pending_items.size() > 0) begin
          req_if.data <= pending_items.pop_front();
          nxt_valid = 1'b1;
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // monitor and result checker
  int rx_wait = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  out_item_t want;
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", rsp_if.data);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.data !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp data=%h addr=%h hit=%b st=%0d last=%b | got data=%h addr=%h hit=%b st=%0d last=%b",
                       want.data_byte, want.byte_address, want.hit, want.status, want.last,
                       rsp_if.data.data_byte, rsp_if.data.byte_address, rsp_if.data.hit,
                       rsp_if.data.status, rsp_if.data.last);
          end
        end
        rx_wait = idle_on ? $urandom_range(0, 13) : 0;
      end else if (rx_wait > 0) rx_wait--;
      if (want_long_hold && !hold_done) begin
        hold_cnt = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) hold_cnt--;
      rsp_if.ready <= (rx_wait == 0 && hold_cnt == 0);
    end
  end

  // watchdog on handshake activity
  int quiet = 0;
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable) || rst) quiet <= 0;
    else if (quiet >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else quiet <= quiet + 1;
  end

  task automatic set_device_size(logic [SIZE_BITS-1:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 64'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dev_size = v;
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || req_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t op(action_t a, logic [ADDR_BITS-1:0] ad,
                                  logic [7:0] wd, logic [3:0] ix, logic eob);
    in_item_t it;
    it.action = a; it.address = ad; it.write_data = wd;
    it.backing_data = $urandom; it.entry_index = ix; it.end_of_burst = eob;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    logic [63:0] ad;
    it.write_data = $urandom; it.backing_data = $urandom;
    it.entry_index = $urandom; it.end_of_burst = $urandom;
    r = $urandom_range(0, 99);
    it.action = r < 45 ? ACT_WRITE : r < 75 ? ACT_READ : r < 88 ? ACT_FLUSH : ACT_TRIM;
    r = $urandom_range(0, 9);
    if (r < 8) ad = (hot_blk[$urandom_range(0, 19)] << 6) +
                   ($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63));
    else if (r == 8) ad = 64'(dev_size) + $urandom_range(0, 4) - 2;
    else ad = {$urandom, $urandom};
    it.address = ad[ADDR_BITS-1:0];
    return it;
  endfunction

  logic [SIZE_BITS-1:0] sizes [5];
  logic [63:0] span;
  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    dev_size = '0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      ent_used[k] = 1'b0; ent_mask[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero device size: everything is refused or empty
    set_device_size('0);
    pending_items.push_back(op(ACT_WRITE, '0, 8'h5a, 4'd0, 1'b1));
    pending_items.push_back(op(ACT_READ, '1, 8'h00, 4'd0, 1'b0));
    pending_items.push_back(op(ACT_FLUSH, '0, 8'h00, 4'd0, 1'b1));
    pending_items.push_back(op(ACT_TRIM, '0, 8'h00, 4'hf, 1'b0));
    drain();

    // full device: top address, fill the table, overflow, flush and trim
    set_device_size({1'b1, {ADDR_BITS{1'b0}}});
    pending_items.push_back(op(ACT_WRITE, '1, 8'hff, 4'd0, 1'b1));
    pending_items.push_back(op(ACT_READ, '1, 8'h00, 4'd0, 1'b0));
    pending_items.push_back(op(ACT_READ, '0, 8'h00, 4'd0, 1'b1));
    for (int k = 0; k < 16; k++)
      pending_items.push_back(op(ACT_WRITE, 48'(k * 64 + k), 8'(k), 4'd0, 1'b0));
    pending_items.push_back(op(ACT_FLUSH, '0, 8'h00, 4'd0, 1'b1));
    pending_items.push_back(op(ACT_TRIM, '0, 8'h00, 4'd1, 1'b0));
    pending_items.push_back(op(ACT_FLUSH, '0, 8'h00, 4'd1, 1'b0));
    pending_items.push_back(op(ACT_READ, 48'd66, 8'h00, 4'd0, 1'b0));
    drain();

    // partial trim of block 1, drop of block 4
    set_device_size(49'd100);
    pending_items.push_back(op(ACT_TRIM, '0, 8'h00, 4'd2, 1'b1));
    pending_items.push_back(op(ACT_TRIM, '0, 8'h00, 4'd5, 1'b0));
    drain();

    sizes[0] = {1'b1, {ADDR_BITS{1'b0}}};
    sizes[1] = 49'd1000;
    sizes[2] = {$urandom, $urandom};
    sizes[3] = 49'd1;
    sizes[4] = {1'b0, {ADDR_BITS{1'b1}}};
    for (int p = 0; p < 5; p++) begin
      set_device_size(sizes[p]);
      idle_on = (p != 3);
      span = (64'(dev_size) >> 6) + 1;
      for (int k = 0; k < 20; k++)
        hot_blk[k] = ({$urandom, $urandom} % span);
      for (int k = 0; k < 62; k++) pending_items.push_back(rand_item());
      if (p == 1) want_long_hold = 1'b1;
      drain();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
